/* src/bmd_pkg.sv */
package bmd_pkg;

  localparam int MEM_ADDR_W = 16;
  localparam int VID_ADDR_W = 14;
  localparam int DATA_W     = 8;

  typedef logic [DATA_W-1:0]     byte_t;
  typedef logic [MEM_ADDR_W-1:0] addr_t;
  typedef logic [VID_ADDR_W-1:0] vid_addr_t;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PORT  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    SRC_ROM  = 3'd0,
    SRC_USER = 3'd1,
    SRC_VID2 = 3'd2,
    SRC_VID3 = 3'd3,
    SRC_NONE = 3'd4
  } src_e;

  localparam addr_t PORT_MASK     = 16'h207F;
  localparam byte_t BANK_PORT     = 8'h7F;
  localparam byte_t VIDEO_PORT    = 8'h80;
  localparam addr_t ROM_LOW_END   = 16'h6000;
  localparam addr_t DISK_ROM_BASE = 16'hE000;
  localparam byte_t NO_DATA       = 8'hFF;
  localparam byte_t ZERO_DATA     = 8'h00;

  // bank latch bits
  localparam int BS_USER_WR_OFF = 0;
  localparam int BS_VID2_WR_ON  = 1;
  localparam int BS_VID3_WR_ON  = 2;
  localparam int BS_ROM_RD_OFF  = 4;
  localparam int BS_USER_RD_OFF = 5;
  localparam int BS_VID_RD_ON   = 6;
  // video latch bits
  localparam int VC_VID2_OFF    = 2;
  localparam int VC_VID3_OFF    = 3;

  typedef struct packed {
    logic [1:0] action;
    addr_t      address;
    byte_t      write_data;
  } in_item_t;

  typedef struct packed {
    byte_t      read_data;
    logic [2:0] source_bank;
  } out_item_t;

  typedef struct packed {
    byte_t bank_sel;
    byte_t video_ctl;
    logic  disk_rom_disable;
    logic  rom_e000_ff;
  } ctl_t;

  typedef struct packed {
    logic      is_read;
    src_e      src;
    logic      rom_re;
    logic      rom_we;
    logic      user_re;
    logic      user_we;
    logic      vid2_re;
    logic      vid2_we;
    logic      vid3_re;
    logic      vid3_we;
    vid_addr_t vid_addr;
    logic      bank_ld;
    logic      video_ld;
    logic      rom_e000_ld;
  } dec_t;

  // mirror map folded into the 16K window: only bit 13 ever changes
  function automatic vid_addr_t video_offset(addr_t a);
    logic flip;
    case (a[15:13])
      3'd1, 3'd2, 3'd5, 3'd6: flip = 1'b1;
      default:                flip = 1'b0;
    endcase
    return {a[13] ^ flip, a[12:0]};
  endfunction

endpackage

/* src/bmd_ram.sv */
module bmd_ram import bmd_pkg::*; #(
  parameter int ADDR_W = MEM_ADDR_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  byte_t             wdata,
  output byte_t             rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/bmd_decode.sv */
module bmd_decode import bmd_pkg::*; (
  input  logic     go,
  input  in_item_t item,
  input  ctl_t     ctl,
  output dec_t     dec
);

  logic  rom_hit;
  logic  port_alias;
  byte_t port_lo;

  always_comb begin
    port_alias = (item.address & PORT_MASK) == PORT_MASK;
    port_lo    = port_alias ? BANK_PORT : item.address[7:0];

    rom_hit = !ctl.bank_sel[BS_ROM_RD_OFF] &&
              ((item.address < ROM_LOW_END) ||
               ((item.address >= DISK_ROM_BASE) && !ctl.rom_e000_ff &&
                !ctl.disk_rom_disable));

    dec          = '0;
    dec.src      = SRC_NONE;
    dec.vid_addr = video_offset(item.address);

    unique case (action_e'(item.action))
      ACT_READ: begin
        dec.is_read = 1'b1;
        if (rom_hit) begin
          dec.src = SRC_ROM;
        end else if (!ctl.bank_sel[BS_USER_RD_OFF]) begin
          dec.src = SRC_USER;
        end else if (ctl.bank_sel[BS_VID_RD_ON]) begin
          if (!ctl.video_ctl[VC_VID2_OFF]) begin
            dec.src = SRC_VID2;
          end else if (!ctl.video_ctl[VC_VID3_OFF]) begin
            dec.src = SRC_VID3;
          end
        end
        dec.rom_re  = go;
        dec.user_re = go;
        dec.vid2_re = go;
        dec.vid3_re = go;
      end
      ACT_WRITE: begin
        dec.user_we = go && !ctl.bank_sel[BS_USER_WR_OFF];
        dec.vid2_we = go && ctl.bank_sel[BS_VID2_WR_ON] && !ctl.video_ctl[VC_VID2_OFF];
        dec.vid3_we = go && ctl.bank_sel[BS_VID3_WR_ON] && !ctl.video_ctl[VC_VID3_OFF];
      end
      ACT_PORT: begin
        dec.bank_ld  = go && (port_lo == BANK_PORT);
        dec.video_ld = go && (port_lo == VIDEO_PORT);
      end
      ACT_LOAD: begin
        dec.rom_we      = go;
        // shadow of the disk rom signature byte
        dec.rom_e000_ld = go && (item.address == DISK_ROM_BASE);
      end
      default: begin
        dec.src = SRC_NONE;
      end
    endcase
  end

endmodule

/* src/banked_memory_decoder_core.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_item (action, address, write_data)
// out      output     out_valid / out_stall out_item (read_data, source_bank)
// cfg      input      cfg_we                cfg_data (disk_rom_disable)
//
// one transaction per cycle sustained while out_stall does not hold the pipeline; the result
// passes through the registered read of the four bank memories, then the output register
// a write, latch load or rom load takes effect at its acceptance edge, so the next
// transaction already sees it
// reset clears the latches, disk_rom_disable and the pipeline; memories are not cleared
// out_stall backs up through the read stage into in_stall in the same cycle
module banked_memory_decoder_core import bmd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  ctl_t  ctl;
  dec_t  dec;
  logic  accept;
  logic  s1_valid;
  logic  s1_is_read;
  src_e  s1_src;
  logic  s1_adv;
  byte_t rom_rd, user_rd, vid2_rd, vid3_rd;
  byte_t rd_mux;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  bmd_decode u_decode (
    .go   (accept),
    .item (in_item),
    .ctl  (ctl),
    .dec  (dec)
  );

  bmd_ram #(.ADDR_W(MEM_ADDR_W)) u_rom (
    .clk   (clk),
    .we    (dec.rom_we),
    .re    (dec.rom_re),
    .addr  (in_item.address),
    .wdata (in_item.write_data),
    .rdata (rom_rd)
  );

  bmd_ram #(.ADDR_W(MEM_ADDR_W)) u_user (
    .clk   (clk),
    .we    (dec.user_we),
    .re    (dec.user_re),
    .addr  (in_item.address),
    .wdata (in_item.write_data),
    .rdata (user_rd)
  );

  bmd_ram #(.ADDR_W(VID_ADDR_W)) u_vid2 (
    .clk   (clk),
    .we    (dec.vid2_we),
    .re    (dec.vid2_re),
    .addr  (dec.vid_addr),
    .wdata (in_item.write_data),
    .rdata (vid2_rd)
  );

  bmd_ram #(.ADDR_W(VID_ADDR_W)) u_vid3 (
    .clk   (clk),
    .we    (dec.vid3_we),
    .re    (dec.vid3_re),
    .addr  (dec.vid_addr),
    .wdata (in_item.write_data),
    .rdata (vid3_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      if (cfg_we) begin
        ctl.disk_rom_disable <= cfg_data;
      end
      if (dec.bank_ld) begin
        ctl.bank_sel <= in_item.write_data;
      end
      if (dec.video_ld) begin
        ctl.video_ctl <= in_item.write_data;
      end
      if (dec.rom_e000_ld) begin
        ctl.rom_e000_ff <= (in_item.write_data == NO_DATA);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_read <= dec.is_read;
      s1_src     <= dec.src;
    end
  end

  always_comb begin
    case (s1_src)
      SRC_ROM:  rd_mux = rom_rd;
      SRC_USER: rd_mux = user_rd;
      SRC_VID2: rd_mux = vid2_rd;
      SRC_VID3: rd_mux = vid3_rd;
      default:  rd_mux = NO_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item.read_data   <= s1_is_read ? rd_mux : ZERO_DATA;
      out_item.source_bank <= s1_src;
    end
  end

endmodule

/* src/bmd_checker.sv */
module bmd_checker import bmd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // output register parts the two sides: input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output transaction changed");

  // no bank answering gives either an empty non-read result or the open-bus byte
  a_none_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.source_bank == SRC_NONE |->
      out_item.read_data == NO_DATA || out_item.read_data == ZERO_DATA)
    else $error("result with no source carries unexpected data");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not cleared by reset");

endmodule

bind banked_memory_decoder_core bmd_checker u_bmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
